// ----- hw/rtl/mlrq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlrq_pkg
// Shared types and constants of the multilevel ready-queue scheduler.
// ----------------------------------------------------------------------------
package mlrq_pkg;

    localparam int TASK_COUNT_DEF  = 64;
    localparam int LEVEL_COUNT_DEF = 4;

    localparam int TASK_ID_W = 6;
    localparam int LEVEL_W   = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TASK  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_LEVEL = 1'd1;

    localparam logic [TASK_ID_W-1:0] IDLE_TASK_RST  = 6'd0;
    localparam logic [LEVEL_W-1:0]   USER_LEVEL_RST = 2'd3;

    typedef enum logic [1:0] {
        OP_READY  = 2'd0,
        OP_REMOVE = 2'd1,
        OP_ROTATE = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_MISS  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // link memory read address source
    typedef enum logic [1:0] {
        RD_TID  = 2'd0,
        RD_T    = 2'd1,
        RD_HEAD = 2'd2,
        RD_LINK = 2'd3
    } rd_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDY_LINK,
        S_RDY_COMMIT,
        S_REM_LVL,
        S_REM_HEAD,
        S_WALK,
        S_UNLINK,
        S_REM_FIN,
        S_ROT_LINK,
        S_ROT_RD,
        S_ROT_FIN,
        S_PICK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    load;
        rd_sel_t rd_sel;
        logic    ready_link;
        logic    ready_commit;
        logic    pick;
        logic    rem_lvl;
        logic    rem_head;
        logic    walk_step;
        logic    unlink;
        logic    rem_fin;
        logic    rot_link;
        logic    rot_fin;
        logic    set_miss;
        logic    set_empty;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic tid_bad;
        logic queued_t;
        logic lvl_empty;
        logic head_is_t;
        logic link_valid;
        logic link_is_t;
        logic steps_over;
        logic choice_is_t;
        logic out_busy;
    } sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/multilevel_ready_queue_scheduler_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multilevel_ready_queue_scheduler_core
// Priority ready-queue scheduler with one linked FIFO list per level.
// ----------------------------------------------------------------------------
// Input words carry an operation (ready, remove, rotate user level), a task
// number and a priority level; each accepted word yields one result word with
// the selected task, an idle flag and a status code. Handshake is valid/ready
// on both sides. Configuration (idle task, user level) is a plain write port.
// Each operation steps through its own sequencer states; a remove walk stops
// after TASK_COUNT list hops. The result shows in the same cycle as the core
// becomes ready again for the next word. The remove walk
// reads one link per cycle through the link memory read port. One word is in
// work at a time. The result sits in an output register: a new word is
// accepted while it waits, and when the receiver stalls the next result is
// held in the sequencer until the register frees up. Reset empties every
// level, clears all queued flags and selects the idle task; no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module multilevel_ready_queue_scheduler_core #(
    parameter int TASK_COUNT  = mlrq_pkg::TASK_COUNT_DEF,
    parameter int LEVEL_COUNT = mlrq_pkg::LEVEL_COUNT_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [mlrq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mlrq_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [1:0]                       s_operation,
    input  wire logic [mlrq_pkg::TASK_ID_W-1:0]   s_task_id,
    input  wire logic [mlrq_pkg::LEVEL_W-1:0]     s_priority_req,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [mlrq_pkg::TASK_ID_W-1:0]        m_selected_task,
    output logic                                  m_selected_is_idle,
    output logic [mlrq_pkg::STATUS_W-1:0]         m_status
);

    mlrq_pkg::cmd_t cmd;
    mlrq_pkg::sts_t sts;

    mlrq_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .sts         (sts),
        .cmd         (cmd)
    );

    mlrq_datapath #(
        .TASK_COUNT  (TASK_COUNT),
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wr_data        (cfg_wr_data),
        .s_operation        (s_operation),
        .s_task_id          (s_task_id),
        .s_priority_req     (s_priority_req),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_selected_task    (m_selected_task),
        .m_selected_is_idle (m_selected_is_idle),
        .m_status           (m_status),
        .cmd                (cmd),
        .sts                (sts)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/mlrq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlrq_ctrl
// Sequencer: steps each operation through the list datapath.
// ----------------------------------------------------------------------------
module mlrq_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [1:0]      s_operation,
    input  wire mlrq_pkg::sts_t  sts,
    output mlrq_pkg::cmd_t       cmd
);

    mlrq_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mlrq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = mlrq_pkg::RD_T;
        s_ready    = 1'b0;
        unique case (state_reg)
            mlrq_pkg::S_IDLE: begin
                s_ready    = 1'b1;
                cmd.rd_sel = mlrq_pkg::RD_TID;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    unique case (mlrq_pkg::op_t'(s_operation))
                        mlrq_pkg::OP_READY: begin
                            cmd.set_miss = sts.tid_bad;
                            state_next = sts.tid_bad ? mlrq_pkg::S_DONE
                                                     : mlrq_pkg::S_RDY_LINK;
                        end
                        mlrq_pkg::OP_REMOVE: begin
                            cmd.set_miss = sts.tid_bad;
                            state_next = sts.tid_bad ? mlrq_pkg::S_DONE
                                                     : mlrq_pkg::S_REM_LVL;
                        end
                        mlrq_pkg::OP_ROTATE: state_next = mlrq_pkg::S_ROT_LINK;
                        default:             state_next = mlrq_pkg::S_DONE;
                    endcase
                end
            end
            mlrq_pkg::S_RDY_LINK: begin
                if (sts.queued_t) begin
                    cmd.set_miss = 1'b1;
                    state_next   = mlrq_pkg::S_DONE;
                end else begin
                    cmd.ready_link = 1'b1;
                    state_next     = mlrq_pkg::S_RDY_COMMIT;
                end
            end
            mlrq_pkg::S_RDY_COMMIT: begin
                cmd.ready_commit = 1'b1;
                state_next       = mlrq_pkg::S_PICK;
            end
            mlrq_pkg::S_REM_LVL: begin
                cmd.rem_lvl = 1'b1;
                if (sts.lvl_empty) begin
                    cmd.set_empty = 1'b1;
                    state_next    = mlrq_pkg::S_DONE;
                end else if (sts.head_is_t) begin
                    cmd.rd_sel = mlrq_pkg::RD_T;
                    state_next = mlrq_pkg::S_REM_HEAD;
                end else begin
                    cmd.rd_sel = mlrq_pkg::RD_HEAD;
                    state_next = mlrq_pkg::S_WALK;
                end
            end
            mlrq_pkg::S_REM_HEAD: begin
                cmd.rem_head = 1'b1;
                state_next   = mlrq_pkg::S_REM_FIN;
            end
            // one list hop per cycle
            mlrq_pkg::S_WALK: begin
                if (sts.steps_over || !sts.link_valid) begin
                    cmd.set_miss = 1'b1;
                    state_next   = mlrq_pkg::S_DONE;
                end else if (sts.link_is_t) begin
                    cmd.rd_sel = mlrq_pkg::RD_T;
                    state_next = mlrq_pkg::S_UNLINK;
                end else begin
                    cmd.rd_sel    = mlrq_pkg::RD_LINK;
                    cmd.walk_step = 1'b1;
                end
            end
            mlrq_pkg::S_UNLINK: begin
                cmd.unlink = 1'b1;
                state_next = mlrq_pkg::S_REM_FIN;
            end
            mlrq_pkg::S_REM_FIN: begin
                cmd.rem_fin = 1'b1;
                state_next  = sts.choice_is_t ? mlrq_pkg::S_PICK : mlrq_pkg::S_DONE;
            end
            mlrq_pkg::S_ROT_LINK: begin
                if (sts.lvl_empty) begin
                    cmd.set_empty = 1'b1;
                    state_next    = mlrq_pkg::S_DONE;
                end else begin
                    cmd.rot_link = 1'b1;
                    state_next   = mlrq_pkg::S_ROT_RD;
                end
            end
            mlrq_pkg::S_ROT_RD: begin
                cmd.rd_sel = mlrq_pkg::RD_HEAD;
                state_next = mlrq_pkg::S_ROT_FIN;
            end
            mlrq_pkg::S_ROT_FIN: begin
                cmd.rot_fin = 1'b1;
                state_next  = mlrq_pkg::S_PICK;
            end
            mlrq_pkg::S_PICK: begin
                cmd.pick   = 1'b1;
                state_next = mlrq_pkg::S_DONE;
            end
            mlrq_pkg::S_DONE: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = mlrq_pkg::S_IDLE;
                end
            end
            default: state_next = mlrq_pkg::S_IDLE;
        endcase
    end

    // assertions
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> state_reg == mlrq_pkg::S_IDLE && s_valid)
        else $error("load outside idle");
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !sts.out_busy)
        else $error("result overwritten while stalled");
    a_walk_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mlrq_pkg::S_WALK && sts.steps_over |=>
            state_reg == mlrq_pkg::S_DONE)
        else $error("walk ran past task count");

endmodule
`default_nettype wire

// ----- hw/rtl/mlrq_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlrq_datapath
// Level lists, link and level memories, selection and result register.
// ----------------------------------------------------------------------------
module mlrq_datapath #(
    parameter int TASK_COUNT  = mlrq_pkg::TASK_COUNT_DEF,
    parameter int LEVEL_COUNT = mlrq_pkg::LEVEL_COUNT_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mlrq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mlrq_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  wire logic [1:0]                        s_operation,
    input  wire logic [mlrq_pkg::TASK_ID_W-1:0]    s_task_id,
    input  wire logic [mlrq_pkg::LEVEL_W-1:0]      s_priority_req,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [mlrq_pkg::TASK_ID_W-1:0]         m_selected_task,
    output logic                                   m_selected_is_idle,
    output logic [mlrq_pkg::STATUS_W-1:0]          m_status,
    input  wire mlrq_pkg::cmd_t                    cmd,
    output mlrq_pkg::sts_t                         sts
);

    localparam int TW = $clog2(TASK_COUNT);
    localparam int LW = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam int CW = $clog2(TASK_COUNT + 1);

    function automatic logic [LW-1:0] clamp_level(input logic [mlrq_pkg::LEVEL_W-1:0] v);
        if (int'(v) >= LEVEL_COUNT) begin
            return LW'(LEVEL_COUNT - 1);
        end
        return LW'(v);
    endfunction

    // configuration
    logic [mlrq_pkg::TASK_ID_W-1:0] idle_task_reg;
    logic [mlrq_pkg::LEVEL_W-1:0]   user_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_task_reg  <= mlrq_pkg::IDLE_TASK_RST;
            user_level_reg <= mlrq_pkg::USER_LEVEL_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == mlrq_pkg::CFG_IDLE_TASK) begin
                idle_task_reg <= cfg_wr_data[mlrq_pkg::TASK_ID_W-1:0];
            end
            if (cfg_index == mlrq_pkg::CFG_USER_LEVEL) begin
                user_level_reg <= cfg_wr_data[mlrq_pkg::LEVEL_W-1:0];
            end
        end
    end

    // list state
    logic [TW-1:0]          head_reg [LEVEL_COUNT];
    logic [TW-1:0]          tail_reg [LEVEL_COUNT];
    logic [LEVEL_COUNT-1:0] nonempty_reg;
    logic [TASK_COUNT-1:0]  queued_reg;
    logic [TW-1:0]          choice_reg;
    logic                   choice_idle_reg;

    // working registers
    logic [TW-1:0]                  t_reg;
    logic [LW-1:0]                  lvl_reg;
    logic [TW-1:0]                  x_reg;
    logic [CW-1:0]                  steps_reg;
    logic [mlrq_pkg::STATUS_W-1:0]  status_reg;

    // memories
    logic [TW:0]   link_mem [TASK_COUNT];
    logic [LW-1:0] tlvl_mem [TASK_COUNT];
    logic [TW:0]   link_rd_reg;
    logic [LW-1:0] tlvl_rd_reg;

    logic [LW-1:0] lvl_cur;
    logic [TW-1:0] rd_addr;
    logic          wr_en;
    logic [TW-1:0] wr_addr;
    logic [TW:0]   wr_data;
    logic [TW-1:0] link_id;
    logic          link_valid;
    logic [LW-1:0] pick_idx;
    logic          pick_any;

    assign lvl_cur    = cmd.rem_lvl ? tlvl_rd_reg : lvl_reg;
    assign link_id    = link_rd_reg[TW-1:0];
    assign link_valid = link_rd_reg[TW];

    // read address select
    always_comb begin
        unique case (cmd.rd_sel)
            mlrq_pkg::RD_TID:  rd_addr = TW'(s_task_id);
            mlrq_pkg::RD_T:    rd_addr = t_reg;
            mlrq_pkg::RD_HEAD: rd_addr = head_reg[lvl_cur];
            mlrq_pkg::RD_LINK: rd_addr = link_id;
            default:           rd_addr = t_reg;
        endcase
    end

    // link write select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = t_reg;
        wr_data = '0;
        priority if (cmd.ready_link) begin
            wr_en   = nonempty_reg[lvl_reg];
            wr_addr = tail_reg[lvl_reg];
            wr_data = {1'b1, t_reg};
        end else if (cmd.ready_commit) begin
            wr_en   = 1'b1;
            wr_addr = t_reg;
        end else if (cmd.unlink) begin
            wr_en   = 1'b1;
            wr_addr = x_reg;
            wr_data = link_rd_reg;
        end else if (cmd.rot_link) begin
            wr_en   = 1'b1;
            wr_addr = tail_reg[lvl_reg];
            wr_data = {1'b1, head_reg[lvl_reg]};
        end else if (cmd.rot_fin) begin
            wr_en   = 1'b1;
            wr_addr = head_reg[lvl_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            link_mem[wr_addr] <= wr_data;
        end
        if (cmd.ready_commit) begin
            tlvl_mem[t_reg] <= lvl_reg;
        end
        link_rd_reg <= link_mem[rd_addr];
        tlvl_rd_reg <= tlvl_mem[rd_addr];
    end

    // lowest-numbered non-empty level
    always_comb begin
        pick_idx = '0;
        pick_any = 1'b0;
        for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
            if (nonempty_reg[i]) begin
                pick_idx = LW'(i);
                pick_any = 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            t_reg   <= TW'(s_task_id);
            lvl_reg <= (mlrq_pkg::op_t'(s_operation) == mlrq_pkg::OP_READY)
                       ? clamp_level(s_priority_req) : clamp_level(user_level_reg);
        end
        if (cmd.rem_lvl) begin
            lvl_reg   <= lvl_cur;
            x_reg     <= head_reg[lvl_cur];
            steps_reg <= '0;
        end
        if (cmd.walk_step) begin
            x_reg     <= link_id;
            steps_reg <= steps_reg + CW'(1);
        end
        if (cmd.load) begin
            status_reg <= mlrq_pkg::ST_DONE;
        end
        if (cmd.set_miss) begin
            status_reg <= mlrq_pkg::ST_MISS;
        end
        if (cmd.set_empty) begin
            status_reg <= mlrq_pkg::ST_EMPTY;
        end
    end

    // level lists and selection
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nonempty_reg    <= '0;
            queued_reg      <= '0;
            choice_reg      <= '0;
            choice_idle_reg <= 1'b1;
            for (int i = 0; i < LEVEL_COUNT; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end else begin
            if (cmd.ready_commit) begin
                if (!nonempty_reg[lvl_reg]) begin
                    head_reg[lvl_reg] <= t_reg;
                end
                nonempty_reg[lvl_reg] <= 1'b1;
                tail_reg[lvl_reg]     <= t_reg;
                queued_reg[t_reg]     <= 1'b1;
            end
            if (cmd.rem_head) begin
                if (link_valid) begin
                    head_reg[lvl_reg] <= link_id;
                end else begin
                    nonempty_reg[lvl_reg] <= 1'b0;
                end
            end
            if (cmd.unlink && tail_reg[lvl_reg] == t_reg) begin
                tail_reg[lvl_reg] <= x_reg;
            end
            if (cmd.rem_fin) begin
                queued_reg[t_reg] <= 1'b0;
            end
            if (cmd.rot_fin) begin
                head_reg[lvl_reg] <= link_id;
                tail_reg[lvl_reg] <= head_reg[lvl_reg];
            end
            if (cmd.pick) begin
                choice_reg      <= pick_any ? head_reg[pick_idx] : '0;
                choice_idle_reg <= !pick_any;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_selected_task    <= choice_idle_reg ? idle_task_reg
                                                  : mlrq_pkg::TASK_ID_W'(choice_reg);
            m_selected_is_idle <= choice_idle_reg;
            m_status           <= status_reg;
        end
    end

    // status to sequencer
    always_comb begin
        sts.tid_bad     = int'(s_task_id) >= TASK_COUNT;
        sts.queued_t    = queued_reg[t_reg];
        sts.lvl_empty   = !nonempty_reg[lvl_cur];
        sts.head_is_t   = head_reg[lvl_cur] == t_reg;
        sts.link_valid  = link_valid;
        sts.link_is_t   = link_id == t_reg;
        sts.steps_over  = steps_reg >= CW'(TASK_COUNT);
        sts.choice_is_t = !choice_idle_reg && choice_reg == t_reg;
        sts.out_busy    = m_valid && !m_ready;
    end

    // assertions
    a_pick_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pick |=> choice_idle_reg == (nonempty_reg == '0))
        else $error("idle flag disagrees with level state");
    a_commit_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ready_commit |=> queued_reg[$past(t_reg)])
        else $error("ready did not mark task queued");
    a_steps_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_step |-> steps_reg < CW'(TASK_COUNT))
        else $error("walk step past bound");

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multilevel ready-queue scheduler core.
// ----------------------------------------------------------------------------
// An in-bench model of the per-level linked lists predicts each result word
// when the input word is accepted. A monitor compares every result word with
// the oldest prediction. Directed words cover field extremes and the corner
// cases. Random phases follow under several idle-task and user-level
// settings. One deep-walk phase fills a single level, and one phase holds
// off the receiver until the core stalls its input.
// ----------------------------------------------------------------------------
module testbench;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [mlrq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mlrq_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [1:0]                      s_operation = '0;
    logic [mlrq_pkg::TASK_ID_W-1:0]  s_task_id = '0;
    logic [mlrq_pkg::LEVEL_W-1:0]    s_priority_req = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [mlrq_pkg::TASK_ID_W-1:0]  m_selected_task;
    logic                            m_selected_is_idle;
    logic [mlrq_pkg::STATUS_W-1:0]   m_status;

    multilevel_ready_queue_scheduler_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_task_id(s_task_id), .s_priority_req(s_priority_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_selected_task(m_selected_task),
        .m_selected_is_idle(m_selected_is_idle), .m_status(m_status)
    );

    typedef struct {
        logic [5:0]        sel;
        logic              idle;
        mlrq_pkg::status_t st;
    } sched_result_t;

    sched_result_t pending_q[$];

    // scheduler model state
    logic [5:0] lvl_head[4];
    logic [5:0] lvl_tail[4];
    logic       lvl_busy[4];
    logic [6:0] succ[64];       // bit 6 = successor valid
    logic       queued[64];
    logic [1:0] home_lvl[64];
    logic       ever_ready[64]; // level known, remove is legal
    logic [5:0] choice;
    logic       choice_idle;
    logic [5:0] idle_id;
    logic [1:0] rr_level;

    int errors = 0;
    int words_sent = 0;
    int results_seen = 0;
    bit quiet = 0;              // no idling on either side
    int hold_req = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("timeout waiting for the scheduler");
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void pick_head();
        int i;
        choice = '0;
        choice_idle = 1'b1;
        for (i = 3; i >= 0; i--) begin
            if (lvl_busy[i]) begin
                choice = lvl_head[i];
                choice_idle = 1'b0;
            end
        end
    endfunction

    function automatic mlrq_pkg::status_t do_ready(logic [5:0] t, logic [1:0] lvl);
        if (queued[t]) return mlrq_pkg::ST_MISS;
        home_lvl[t] = lvl;
        ever_ready[t] = 1'b1;
        if (lvl_busy[lvl]) succ[lvl_tail[lvl]] = {1'b1, t};
        else lvl_head[lvl] = t;
        lvl_busy[lvl] = 1'b1;
        succ[t] = '0;
        lvl_tail[lvl] = t;
        queued[t] = 1'b1;
        pick_head();
        return mlrq_pkg::ST_DONE;
    endfunction

    function automatic mlrq_pkg::status_t do_remove(logic [5:0] t);
        logic [1:0] lvl;
        logic [5:0] x;
        logic [5:0] n;
        int steps;
        lvl = home_lvl[t];
        if (!lvl_busy[lvl]) return mlrq_pkg::ST_EMPTY;
        x = lvl_head[lvl];
        if (x == t) begin
            if (succ[t][6]) lvl_head[lvl] = succ[t][5:0];
            else lvl_busy[lvl] = 1'b0;
        end else begin
            steps = 0;
            forever begin
                if (steps >= 64 || !succ[x][6]) return mlrq_pkg::ST_MISS;
                n = succ[x][5:0];
                if (n == t) break;
                x = n;
                steps++;
            end
            succ[x] = succ[t];
            if (lvl_tail[lvl] == t) lvl_tail[lvl] = x;
        end
        queued[t] = 1'b0;
        if (!choice_idle && choice == t) pick_head();
        return mlrq_pkg::ST_DONE;
    endfunction

    function automatic mlrq_pkg::status_t do_rotate();
        logic [1:0] lvl;
        logic [5:0] h;
        logic [5:0] tl;
        lvl = rr_level;
        if (!lvl_busy[lvl]) return mlrq_pkg::ST_EMPTY;
        h = lvl_head[lvl];
        tl = lvl_tail[lvl];
        succ[tl] = {1'b1, h};
        lvl_tail[lvl] = h;
        lvl_head[lvl] = succ[h][5:0];
        succ[h] = '0;
        pick_head();
        return mlrq_pkg::ST_DONE;
    endfunction

    function automatic sched_result_t predict_word(mlrq_pkg::op_t op, logic [5:0] t,
                                                   logic [1:0] p);
        sched_result_t r;
        r.st = mlrq_pkg::ST_DONE;
        case (op)
            mlrq_pkg::OP_READY:  r.st = do_ready(t, p);
            mlrq_pkg::OP_REMOVE: r.st = do_remove(t);
            mlrq_pkg::OP_ROTATE: r.st = do_rotate();
            default:             r.st = mlrq_pkg::ST_DONE;
        endcase
        r.idle = choice_idle;
        r.sel = choice_idle ? idle_id : choice;
        return r;
    endfunction

    // send one word; the prediction is queued at the accepting edge
    task automatic send_word(mlrq_pkg::op_t op, logic [5:0] t, logic [1:0] p);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = (quiet || r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_task_id <= t;
        s_priority_req <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_q.push_back(predict_word(op, t, p));
        words_sent++;
    endtask

    task automatic drain();
        @(posedge aclk);
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [mlrq_pkg::CFG_IDX_W-1:0] idx, logic [5:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == mlrq_pkg::CFG_IDLE_TASK) idle_id = val;
        else rr_level = val[1:0];
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin : receiver
        int stall;
        int r;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (hold_req > 0) begin
                stall = hold_req;
                hold_req = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 12) stall = $urandom_range(1, 3);
                else if (r < 14) stall = $urandom_range(10, 40);
                m_ready <= (stall == 0);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        sched_result_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_q.size() == 0) begin
                $error("result word with no prediction waiting");
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (m_selected_task !== e.sel) begin
                    $error("selected_task expected %0d got %0d", e.sel, m_selected_task);
                    errors++;
                end
                if (m_selected_is_idle !== e.idle) begin
                    $error("selected_is_idle expected %0d got %0d", e.idle,
                           m_selected_is_idle);
                    errors++;
                end
                if (m_status !== e.st) begin
                    $error("status expected %0d got %0d", e.st, m_status);
                    errors++;
                end
            end
        end
    end

    // random word: mostly legal list traffic, some misses and no-ops
    task automatic random_word(int pool);
        int r;
        logic [5:0] t;
        r = $urandom_range(0, 99);
        t = (pool >= 64) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, pool - 1) * 64 / pool);
        if (r < 3) begin
            send_word(mlrq_pkg::OP_NOP, 6'($urandom), 2'($urandom));
        end else if (r < 20) begin
            send_word(mlrq_pkg::OP_ROTATE, t, 2'($urandom));
        end else if (r < 55 || !ever_ready[t]) begin
            send_word(mlrq_pkg::OP_READY, t, 2'($urandom));
        end else begin
            send_word(mlrq_pkg::OP_REMOVE, t, 2'($urandom));
        end
    endtask

    task automatic test_directed();
        int i;
        write_cfg(mlrq_pkg::CFG_IDLE_TASK, 6'd63);
        send_word(mlrq_pkg::OP_ROTATE, 6'd0, 2'd0);    // rotate of empty level
        send_word(mlrq_pkg::OP_NOP, 6'd63, 2'd3);      // no-op
        send_word(mlrq_pkg::OP_READY, 6'd63, 2'd3);
        send_word(mlrq_pkg::OP_READY, 6'd0, 2'd3);
        send_word(mlrq_pkg::OP_READY, 6'd0, 2'd3);     // already queued
        send_word(mlrq_pkg::OP_READY, 6'd21, 2'd2);
        send_word(mlrq_pkg::OP_READY, 6'd42, 2'd0);
        send_word(mlrq_pkg::OP_READY, 6'd5, 2'd0);
        send_word(mlrq_pkg::OP_ROTATE, 6'd0, 2'd0);    // user level 3
        send_word(mlrq_pkg::OP_REMOVE, 6'd0, 2'd0);    // not the selected task
        send_word(mlrq_pkg::OP_REMOVE, 6'd0, 2'd0);    // no longer in its list
        send_word(mlrq_pkg::OP_REMOVE, 6'd42, 2'd1);   // selected task, re-pick
        send_word(mlrq_pkg::OP_REMOVE, 6'd5, 2'd0);
        send_word(mlrq_pkg::OP_REMOVE, 6'd5, 2'd0);    // its level is empty
        send_word(mlrq_pkg::OP_REMOVE, 6'd21, 2'd0);
        send_word(mlrq_pkg::OP_REMOVE, 6'd63, 2'd0);   // back to idle
        write_cfg(mlrq_pkg::CFG_USER_LEVEL, 2'd0);
        for (i = 0; i < 3; i++) send_word(mlrq_pkg::OP_READY, 6'(10 + i), 2'd0);
        send_word(mlrq_pkg::OP_ROTATE, 6'd0, 2'd0);
        send_word(mlrq_pkg::OP_REMOVE, 6'd12, 2'd0);   // removal from the middle of the list
        send_word(mlrq_pkg::OP_ROTATE, 6'd0, 2'd0);
        send_word(mlrq_pkg::OP_REMOVE, 6'd10, 2'd0);
        send_word(mlrq_pkg::OP_REMOVE, 6'd11, 2'd0);
    endtask

    task automatic test_random_settings();
        int ph;
        int i;
        for (ph = 0; ph < 8; ph++) begin
            write_cfg(mlrq_pkg::CFG_IDLE_TASK,
                      (ph == 0) ? 6'd0 : (ph == 1) ? 6'd63 : 6'($urandom));
            write_cfg(mlrq_pkg::CFG_USER_LEVEL, 2'(ph));
            quiet = (ph == 5);
            for (i = 0; i < 150; i++) random_word((ph % 3 == 0) ? 8 : 64);
        end
        quiet = 0;
    endtask

    // whole population on one level, then removals far down the list
    task automatic test_deep_walk();
        int i;
        write_cfg(mlrq_pkg::CFG_USER_LEVEL, 2'd1);
        for (i = 0; i < 64; i++) begin
            if (queued[i]) send_word(mlrq_pkg::OP_REMOVE, 6'(i), 2'd0);
        end
        for (i = 0; i < 64; i++) send_word(mlrq_pkg::OP_READY, 6'(i), 2'd1);
        for (i = 0; i < 10; i++) send_word(mlrq_pkg::OP_ROTATE, 6'd0, 2'd0);
        for (i = 63; i >= 0; i -= 3) send_word(mlrq_pkg::OP_REMOVE, 6'(i), 2'd0);
        for (i = 0; i < 150; i++) random_word(64);
    endtask

    task automatic test_backpressure();
        int i;
        drain();
        hold_req = 400;
        quiet = 1;
        for (i = 0; i < 30; i++) random_word(64);
        quiet = 0;
        for (i = 0; i < 100; i++) random_word(16);
    endtask

    initial begin : main
        int i;
        for (i = 0; i < 4; i++) begin
            lvl_head[i] = '0; lvl_tail[i] = '0; lvl_busy[i] = 1'b0;
        end
        for (i = 0; i < 64; i++) begin
            succ[i] = '0; queued[i] = 1'b0; home_lvl[i] = '0; ever_ready[i] = 1'b0;
        end
        choice = '0;
        choice_idle = 1'b1;
        idle_id = mlrq_pkg::IDLE_TASK_RST;
        rr_level = mlrq_pkg::USER_LEVEL_RST;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_settings();
        test_deep_walk();
        test_backpressure();
        drain();

        if (pending_q.size() != 0) errors++;
        $display("covered %0d words and %0d results: ready, remove, rotate, no-op,",
                 words_sent, results_seen);
        $display("deep list walks, config sweeps and a long receiver hold-off");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/mlrq_pkg.sv
hw/rtl/mlrq_ctrl.sv
hw/rtl/mlrq_datapath.sv
hw/rtl/multilevel_ready_queue_scheduler_core.sv
verif/testbench.sv
